// ===== src/hopped_chirp_sample_generator_defines.svh =====
// assertion macros for the chirp sample generator checker
`ifndef HOPPED_CHIRP_SAMPLE_GENERATOR_DEFINES_SVH
`define HOPPED_CHIRP_SAMPLE_GENERATOR_DEFINES_SVH

// same-cycle implication, ignored during reset
`define HCSG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hcsg check failed");

// next-cycle implication, ignored during reset
`define HCSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcsg check failed");

// next-cycle implication, also checked across reset
`define HCSG_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hcsg check failed");

`endif

// ===== src/hcsg_pkg.sv =====
// shared constants, widths and arctangent table for the chirp sample generator
`default_nettype none
package hcsg_pkg;
    localparam int unsigned MAX_SAMPLES_DEF = 8192;
    localparam int unsigned PHASE_BITS_DEF  = 32;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    localparam int unsigned CORDIC_STEPS = 24;
    localparam int unsigned CW           = 34;   // cordic datapath width
    localparam logic [31:0] CORDIC_GAIN  = 32'd2608131496;

    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 32;

    typedef enum logic [CFG_AW-1:0] {
        CFG_CHIRP_COEF  = 3'd0,
        CFG_HALF_WINDOW = 3'd1,
        CFG_CARRIER_ON  = 3'd2,
        CFG_AMPLITUDE   = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] chirp_coef;
        logic [12:0] half_window;
        logic        carrier_on;
        logic [14:0] amplitude;
    } t_cfg;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 win;
        logic                 valid;
    } t_rot;

    function automatic logic signed [CW-1:0] atan_turns(input int unsigned k);
        logic [31:0] v;
        unique case (k)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10680862;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return $signed({{(CW-32){1'b0}}, v});
    endfunction
endpackage
`default_nettype wire

// ===== src/hcsg_phase.sv =====
// window test and chirp phase accumulation pipeline, four stages
`default_nettype none
module hcsg_phase #(
    parameter int unsigned MAX_SAMPLES = hcsg_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned PHASE_BITS  = hcsg_pkg::PHASE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [12:0]    i_sample_index,
    input  wire logic [23:0]    i_delay_offset,
    input  wire logic [31:0]    i_carrier_step,
    input  wire logic [31:0]    i_phase_offset,
    input  wire hcsg_pkg::t_cfg i_cfg,
    output logic                o_valid,
    output logic                o_win,
    output logic [31:0]         o_phase
);
    import hcsg_pkg::*;

    localparam bit          IDX_WIDE  = MAX_SAMPLES >= 8192;
    localparam bit          IDX_POW2  = (MAX_SAMPLES & (MAX_SAMPLES - 1)) == 0;
    localparam logic [12:0] IDX_MASK  = 13'(MAX_SAMPLES - 1);
    localparam logic [22:0] IDX_RECIP =
        23'((32'd67108864 + MAX_SAMPLES - 1) / MAX_SAMPLES);
    localparam logic [13:0] IDX_MOD   = 14'(MAX_SAMPLES);
    localparam logic [31:0] PH_MASK = 32'hFFFF_FFFF << (32 - PHASE_BITS);

    logic [12:0]        idx;
    logic [35:0]        idx_prod;
    logic [9:0]         idx_quot;
    logic [23:0]        idx_sub;
    logic [12:0]        idx_rem;
    logic signed [24:0] tau;
    logic [24:0]        atau_w;
    logic [44:0]        ramp_full;

    logic        r1_valid, r1_win;
    logic [23:0] r1_atau;
    logic [31:0] r1_ramp, r1_poff;
    logic        r2_valid, r2_win;
    logic [47:0] r2_sq;
    logic [31:0] r2_lin;
    logic        r3_valid, r3_win;
    logic [47:0] r3_plo;
    logic [23:0] r3_phi;
    logic [31:0] r3_lin;
    logic        r4_valid, r4_win;
    logic [31:0] r4_ph;

    logic [55:0] plo_full;
    logic [47:0] phi_full;
    logic [47:0] sum48;

    always_comb begin
        // remainder by reciprocal multiply when the depth is not a power of two
        idx_prod  = 36'(i_sample_index) * 36'(IDX_RECIP);
        idx_quot  = idx_prod[35:26];
        idx_sub   = 24'(idx_quot) * 24'(IDX_MOD);
        idx_rem   = i_sample_index - idx_sub[12:0];
        if (IDX_WIDE) begin
            idx = i_sample_index;
        end else if (IDX_POW2) begin
            idx = i_sample_index & IDX_MASK;
        end else begin
            idx = idx_rem;
        end
        tau       = $signed({i_delay_offset[23], i_delay_offset})
                  + $signed({4'b0, idx, 8'b0});
        atau_w    = tau[24] ? 25'(-tau) : 25'(tau);
        ramp_full = 45'(i_carrier_step) * 45'(idx);
        plo_full  = 56'(i_cfg.chirp_coef) * 56'(r2_sq[23:0]);
        phi_full  = 48'(i_cfg.chirp_coef[23:0]) * 48'(r2_sq[47:24]);
        sum48     = r3_plo + {r3_phi, 24'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_atau <= atau_w[23:0];
            r1_win  <= atau_w <= {4'b0, i_cfg.half_window, 8'b0};
            r1_ramp <= i_cfg.carrier_on ? ramp_full[31:0] : 32'd0;
            r1_poff <= i_phase_offset;
            r2_sq   <= 48'(r1_atau) * 48'(r1_atau);
            r2_lin  <= r1_ramp + r1_poff;
            r2_win  <= r1_win;
            r3_plo  <= plo_full[47:0];
            r3_phi  <= phi_full[23:0];
            r3_lin  <= r2_lin;
            r3_win  <= r2_win;
            r4_ph   <= (sum48[47:16] + r3_lin) & PH_MASK;
            r4_win  <= r3_win;
        end
    end

    assign o_valid = r4_valid;
    assign o_win   = r4_win;
    assign o_phase = r4_ph;
endmodule
`default_nettype wire

// ===== src/hcsg_cordic_cell.sv =====
// one rotation step of the cordic chain
`default_nettype none
module hcsg_cordic_cell #(
    parameter int unsigned STEP = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire hcsg_pkg::t_rot i_rot,
    output hcsg_pkg::t_rot      o_rot
);
    import hcsg_pkg::*;

    localparam logic signed [CW-1:0] ANGLE = atan_turns(STEP);

    t_rot r_rot, n_rot;
    logic signed [CW-1:0] dx, dy;

    always_comb begin
        dx    = i_rot.y >>> STEP;
        dy    = i_rot.x >>> STEP;
        n_rot = i_rot;
        if (!i_rot.z[CW-1]) begin
            n_rot.x = i_rot.x - dx;
            n_rot.y = i_rot.y + dy;
            n_rot.z = i_rot.z - ANGLE;
        end else begin
            n_rot.x = i_rot.x + dx;
            n_rot.y = i_rot.y - dy;
            n_rot.z = i_rot.z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.valid <= 1'b0;
        end else if (i_en) begin
            r_rot.valid <= n_rot.valid;
        end
        if (i_en) begin
            r_rot.x   <= n_rot.x;
            r_rot.y   <= n_rot.y;
            r_rot.z   <= n_rot.z;
            r_rot.win <= n_rot.win;
        end
    end

    assign o_rot = r_rot;
endmodule
`default_nettype wire

// ===== src/hopped_chirp_sample_generator.sv =====
// top level: chirp phase pipeline, quadrant fold, cordic cell row, output register
//
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | sample_index, delay_offset, carrier_step, phase_offset
// output  | out       | o_valid / i_stall  | i_out, q_out, in_window
// config  | in        | i_cfg_we           | i_cfg_addr, i_cfg_data
//
// one transaction per cycle while the output is not stalled; 4 phase stages, 1 fold, 24 cordic cells, 1 output
// the whole pipeline holds while a finished result is stalled at the output register
// reset clears valid bits and loads the register reset values; no clearing pass
`default_nettype none
module hopped_chirp_sample_generator #(
    parameter int unsigned MAX_SAMPLES = hcsg_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned PHASE_BITS  = hcsg_pkg::PHASE_BITS_DEF,
    parameter int unsigned SAMPLE_BITS = hcsg_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hcsg_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [hcsg_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [12:0]                 i_sample_index,
    input  wire logic [23:0]                 i_delay_offset,
    input  wire logic [31:0]                 i_carrier_step,
    input  wire logic [31:0]                 i_phase_offset,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [15:0]               o_i_out,
    output logic signed [15:0]               o_q_out,
    output logic                             o_in_window
);
    import hcsg_pkg::*;

    localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1073741824);
    localparam logic signed [CW-1:0] HALF    = CW'(64'sd32768);
    localparam logic signed [17:0] S_HI = 18'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [17:0] S_LO = -S_HI - 18'sd1;

    t_cfg r_cfg;
    logic en;

    logic        ph_valid, ph_win;
    logic [31:0] ph_phase;

    t_rot r_fold, n_fold;
    t_rot chain [CORDIC_STEPS+1];
    logic [46:0] mag_full;
    logic signed [CW-1:0] mag, z0;

    logic signed [CW-1:0] xr, yr;
    logic signed [17:0] xs, ys, xc, yc;
    logic r_out_valid, r_out_win;
    logic signed [15:0] r_out_i, r_out_q;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chirp_coef  <= 32'd0;
            r_cfg.half_window <= 13'd0;
            r_cfg.carrier_on  <= 1'b1;
            r_cfg.amplitude   <= 15'd32767;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CHIRP_COEF:  r_cfg.chirp_coef  <= i_cfg_data[31:0];
                CFG_HALF_WINDOW: r_cfg.half_window <= i_cfg_data[12:0];
                CFG_CARRIER_ON:  r_cfg.carrier_on  <= i_cfg_data[0];
                CFG_AMPLITUDE:   r_cfg.amplitude   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    hcsg_phase #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_valid),
        .i_sample_index(i_sample_index),
        .i_delay_offset(i_delay_offset),
        .i_carrier_step(i_carrier_step),
        .i_phase_offset(i_phase_offset),
        .i_cfg         (r_cfg),
        .o_valid       (ph_valid),
        .o_win         (ph_win),
        .o_phase       (ph_phase)
    );

    // fold the phase into the right half plane before the rotations
    always_comb begin
        mag_full    = 47'(r_cfg.amplitude) * 47'(CORDIC_GAIN);
        mag         = CW'(mag_full[46:16]);
        z0          = CW'($signed(ph_phase));
        n_fold.win   = ph_win;
        n_fold.valid = ph_valid;
        if (z0 > QUARTER) begin
            n_fold.x = '0;
            n_fold.y = mag;
            n_fold.z = z0 - QUARTER;
        end else if (z0 < -QUARTER) begin
            n_fold.x = '0;
            n_fold.y = -mag;
            n_fold.z = z0 + QUARTER;
        end else begin
            n_fold.x = mag;
            n_fold.y = '0;
            n_fold.z = z0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold.valid <= 1'b0;
        end else if (en) begin
            r_fold.valid <= n_fold.valid;
        end
        if (en) begin
            r_fold.x   <= n_fold.x;
            r_fold.y   <= n_fold.y;
            r_fold.z   <= n_fold.z;
            r_fold.win <= n_fold.win;
        end
    end

    assign chain[0] = r_fold;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        hcsg_cordic_cell #(.STEP(k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_rot  (chain[k]),
            .o_rot  (chain[k+1])
        );
    end

    // round, saturate, zero outside the window
    always_comb begin
        xr = (chain[CORDIC_STEPS].x + HALF) >>> 16;
        yr = (chain[CORDIC_STEPS].y + HALF) >>> 16;
        xs = xr[17:0];
        ys = yr[17:0];
        xc = (xs > S_HI) ? S_HI : ((xs < S_LO) ? S_LO : xs);
        yc = (ys > S_HI) ? S_HI : ((ys < S_LO) ? S_LO : ys);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain[CORDIC_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_win <= chain[CORDIC_STEPS].win;
            r_out_i   <= chain[CORDIC_STEPS].win ? xc[15:0] : 16'sd0;
            r_out_q   <= chain[CORDIC_STEPS].win ? yc[15:0] : 16'sd0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_in_window = r_out_win;
    assign o_i_out     = r_out_i;
    assign o_q_out     = r_out_q;
endmodule
`default_nettype wire

// ===== src/hcsg_checker.sv =====
// port-level checks for the chirp sample generator, bound to the top level
`default_nettype none
`include "hopped_chirp_sample_generator_defines.svh"
module hcsg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_i_out,
    input wire logic [15:0] o_q_out,
    input wire logic        o_in_window
);
    `HCSG_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !o_valid)
    `HCSG_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall)
    `HCSG_ASSERT_NOW(a_zero_outside, o_valid && !o_in_window, o_i_out == 16'd0 && o_q_out == 16'd0)
    `HCSG_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_i_out) && $stable(o_q_out))
endmodule

bind hopped_chirp_sample_generator hcsg_checker u_hcsg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_i_out    (o_i_out),
    .o_q_out    (o_q_out),
    .o_in_window(o_in_window)
);
`default_nettype wire

// ===== verif/tb_hopped_chirp_sample_generator.sv =====
// self-checking testbench for the hopped chirp sample generator
`default_nettype none

class chirp_sample_scoreboard;
    typedef struct {
        logic signed [15:0] i_val;
        logic signed [15:0] q_val;
        logic               win;
    } t_sample;

    localparam longint GAIN_Q32 = 64'd2608131496;

    logic [31:0] chirp_coef;
    logic [12:0] half_window;
    logic        carrier_on;
    logic [14:0] amplitude;
    t_sample     pending[$];
    int          errors;
    int          checked;
    int          inside_cnt;
    longint      atan_tab[24];

    function new();
        atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10680862, 5340245, 2670163, 1335087, 667544, 333772,
                     166886, 83443, 41722, 20861, 10430, 5215,
                     2608, 1304, 652, 326, 163, 81};
        reset_regs();
    endfunction

    function void reset_regs();
        chirp_coef  = '0;
        half_window = '0;
        carrier_on  = 1'b1;
        amplitude   = 15'd32767;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            hcsg_pkg::CFG_CHIRP_COEF:  chirp_coef  = data;
            hcsg_pkg::CFG_HALF_WINDOW: half_window = data[12:0];
            hcsg_pkg::CFG_CARRIER_ON:  carrier_on  = data[0];
            hcsg_pkg::CFG_AMPLITUDE:   amplitude   = data[14:0];
            default: ;
        endcase
    endfunction

    function longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // cordic rotation of amplitude by the phase, rounded to output lsbs
    function void rotate_phase(logic [31:0] ph, output longint ci, output longint si);
        longint mag, x, y, z, dx, dy;
        mag = (longint'(amplitude) * GAIN_Q32) >>> 16;
        z = longint'($signed(ph));
        x = mag;
        y = 0;
        if (z > 64'sd1073741824) begin
            x = 0; y = mag; z -= 64'sd1073741824;
        end else if (z < -64'sd1073741824) begin
            x = 0; y = -mag; z += 64'sd1073741824;
        end
        for (int k = 0; k < 24; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[k];
            end else begin
                x += dx; y -= dy; z += atan_tab[k];
            end
        end
        ci = clip16((x + 32768) >>> 16);
        si = clip16((y + 32768) >>> 16);
    endfunction

    function void note_input(logic [12:0] idx, logic [23:0] dly, logic [31:0] step,
                             logic [31:0] poff);
        t_sample     s;
        longint      tau, ci, si;
        logic [63:0] atau, sq, prod, ph;
        tau = longint'($signed(dly)) + longint'(idx) * 256;
        atau = (tau < 0) ? -tau : tau;
        s = '{16'sd0, 16'sd0, 1'b0};
        if (atau <= 64'(half_window) * 256) begin
            sq = atau * atau;
            prod = 64'(chirp_coef) * sq;
            ph = (prod >> 16) & 64'hFFFF_FFFF;
            if (carrier_on) ph += 64'(step) * 64'(idx);
            ph += 64'(poff);
            rotate_phase(ph[31:0], ci, si);
            s = '{ci[15:0], si[15:0], 1'b1};
            inside_cnt++;
        end
        pending.push_back(s);
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
                 checked);
        errors++;
    endtask

    task check_result(logic signed [15:0] i_val, logic signed [15:0] q_val, logic win);
        t_sample s;
        if (pending.size() == 0) begin
            $display("result with no transaction outstanding");
            errors++;
            return;
        end
        s = pending.pop_front();
        if (i_val !== s.i_val) report("i_out", i_val, s.i_val);
        if (q_val !== s.q_val) report("q_out", q_val, s.q_val);
        if (win !== s.win) report("in_window", win, s.win);
        checked++;
    endtask
endclass

module tb_hopped_chirp_sample_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import hcsg_pkg::*;

    localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd6;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT   = 4000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]  i_cfg_addr = '0;
    logic [CFG_DW-1:0]  i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [12:0]        i_sample_index = '0;
    logic [23:0]        i_delay_offset = '0;
    logic [31:0]        i_carrier_step = '0;
    logic [31:0]        i_phase_offset = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_i_out;
    logic signed [15:0] o_q_out;
    logic               o_in_window;

    chirp_sample_scoreboard sb = new();
    int  stall_left = 0;
    int  idle_cycles = 0;
    int  sent = 0;
    bit  calm = 1'b0;

    hopped_chirp_sample_generator dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // output side: check accepted transactions, draw the next stall length
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_i_out, o_q_out, o_in_window);
            stall_left = calm ? 0 : $urandom_range(0, 15);
        end
        if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task write_cfg(logic [CFG_AW-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    task send_sample(logic [12:0] idx, logic [23:0] dly, logic [31:0] step, logic [31:0] poff);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample_index = idx;
        i_delay_offset = dly;
        i_carrier_step = step;
        i_phase_offset = poff;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(idx, dly, step, poff);
        sent++;
    endtask

    task drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // random transaction, mostly aimed inside the current window
    task send_random();
        logic [12:0] idx;
        longint      tau, hw;
        logic [23:0] dly;
        idx = 13'($urandom_range(0, 8191));
        hw = longint'(sb.half_window) * 256;
        case ($urandom_range(0, 9))
            0, 1: dly = 24'($urandom);
            2: begin
                tau = ($urandom_range(0, 1) ? hw : -hw) + $urandom_range(0, 2) - 1;
                dly = 24'(tau - longint'(idx) * 256);
            end
            default: begin
                tau = longint'($urandom_range(0, 2 * hw)) - hw;
                dly = 24'(tau - longint'(idx) * 256);
            end
        endcase
        send_sample(idx, dly, $urandom, $urandom);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: window of zero width, only tau == 0 is inside
        send_sample(13'd0, 24'd0, 32'd0, 32'd0);
        send_sample(13'd1, 24'hFFFF00, 32'hFFFF_FFFF, 32'h4000_0000);
        send_sample(13'd0, 24'd1, 32'd0, 32'd0);
        send_sample(13'd8191, 24'h800000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(13'd8191, 24'h7FFFFF, 32'd0, 32'h8000_0000);
        drain();

        write_cfg(CFG_CHIRP_COEF, 32'hFFFF_FFFF);
        write_cfg(CFG_HALF_WINDOW, 32'd100);
        write_cfg(CFG_CARRIER_ON, 32'd0);
        write_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
        // window edges, both signs, and just beyond
        send_sample(13'd0, 24'd25600, 32'h1234_5678, 32'd0);
        send_sample(13'd0, 24'd25601, 32'h1234_5678, 32'd0);
        send_sample(13'd0, -24'sd25600, 32'd0, 32'hC000_0000);
        send_sample(13'd0, -24'sd25601, 32'd0, 32'd0);
        send_sample(13'd200, -24'sd25600, 32'hFFFF_FFFF, 32'h8000_0001);
        send_sample(13'd50, -24'sd12800, 32'hFFFF_FFFF, 32'h3FFF_FFFF);
        drain();

        write_cfg(CFG_HALF_WINDOW, 32'd8191);
        write_cfg(CFG_AMPLITUDE, 32'd0);
        write_cfg(CFG_CARRIER_ON, 32'd1);
        send_sample(13'd8191, 24'h800000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(13'd8191, 24'h7FFFFF, 32'hAAAA_5555, 32'h5555_AAAA);
        send_sample(13'd1234, 24'h000000, 32'h0000_0001, 32'h8000_0000);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            calm = (ph % 3 == 1);
            write_cfg(CFG_CHIRP_COEF, (ph == 0) ? 32'd0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom);
            write_cfg(CFG_HALF_WINDOW, (ph == 2) ? 32'd0 : (ph == 3) ? 32'd8191 :
                      (ph == 4) ? 32'd4096 : $urandom_range(1, 4096));
            write_cfg(CFG_CARRIER_ON, ph % 2);
            write_cfg(CFG_AMPLITUDE, (ph == 5) ? 32'd1 : (ph < 3) ? 32'd32767 :
                      $urandom_range(0, 32767));
            repeat (110) send_random();
            drain();
        end

        $display("%0d transactions sent, %0d results checked, %0d inside the window",
                 sent, sb.checked, sb.inside_cnt);
        $display("covered register extremes, window edges and random stalls on both sides");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire
